@@ sv/fme_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the fuzzy membership evaluator.
package fme_pkg;

    localparam int VALUE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SHAPE_BITS     = 3;
    localparam int CFG_INDEX_BITS = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHAPE_KIND = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_A    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_B    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_C    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POINT_D    = 3'd4;

    typedef enum logic [SHAPE_BITS-1:0] {
        SHAPE_LEFT_SHOULDER  = 3'd0,
        SHAPE_RIGHT_SHOULDER = 3'd1,
        SHAPE_TRIANGLE       = 3'd2,
        SHAPE_TRAPEZOID      = 3'd3,
        SHAPE_INTERVAL       = 3'd4,
        SHAPE_SINGLETON      = 3'd5
    } shape_t;

    // Sideband that travels alongside each word in the divider pipeline
    typedef struct packed {
        logic valid;
        logic zero_span;
    } fme_side_t;

endpackage

@@ sv/fme_div_pipe.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: quot = num * 2^FRACTION_BITS / den, with num <= den.
module fme_div_pipe #(
    parameter int NUM_BITS      = fme_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = fme_pkg::FRACTION_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fme_pkg::fme_side_t      in_side,
    input  logic [NUM_BITS-1:0]     num,
    input  logic [NUM_BITS-1:0]     den,
    output fme_pkg::fme_side_t      out_side,
    output logic [FRACTION_BITS:0]  quot
);
    import fme_pkg::*;

    localparam int STAGES = FRACTION_BITS + 1;

    fme_side_t              side_reg [STAGES];
    logic [NUM_BITS-1:0]    rem_reg  [STAGES];
    logic [NUM_BITS-1:0]    den_reg  [STAGES];
    logic [FRACTION_BITS:0] quot_reg [STAGES];

    // Leading bit: num <= den, so the integer bit is set only when they match
    logic                ge_first;
    logic [NUM_BITS-1:0] rem_first_next;

    always_comb
    begin
        ge_first       = (num >= den);
        rem_first_next = ge_first ? (num - den) : num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else
        begin
            side_reg[0] <= in_side;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= rem_first_next;
        den_reg[0]  <= den;
        quot_reg[0] <= {{FRACTION_BITS{1'b0}}, ge_first};
    end

    // One fraction bit per stage
    for (genvar k = 1; k < STAGES; k++)
    begin : g_stage
        logic [NUM_BITS:0]   rem_shift;
        logic                ge;
        logic [NUM_BITS:0]   rem_sub;
        logic [NUM_BITS-1:0] rem_next;

        always_comb
        begin
            rem_shift = {rem_reg[k-1], 1'b0};
            ge        = (rem_shift >= {1'b0, den_reg[k-1]});
            rem_sub   = rem_shift - {1'b0, den_reg[k-1]};
            rem_next  = ge ? rem_sub[NUM_BITS-1:0] : rem_shift[NUM_BITS-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[k] <= '0;
            end
            else
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_reg[k-1];
            quot_reg[k] <= {quot_reg[k-1][FRACTION_BITS-1:0], ge};
        end
    end

    assign out_side = side_reg[STAGES-1];
    assign quot     = quot_reg[STAGES-1];

endmodule

@@ sv/fuzzy_membership_evaluator.sv @@
`timescale 1ns / 1ps
// Top level of the fuzzy membership evaluator: registers, segment select, divider, output.
//
//  channel   ports                                    handshake
//  -------   --------------------------------------   -------------------------------
//  input     crisp_value                              start high, busy low at the edge
//  result    membership_degree, zero_span             done high for one cycle
//  config    cfg_index, cfg_wdata                     cfg_wr_en high at the edge
//
// A word enters on every cycle; busy stays low, since the pipeline never holds.
// The pipeline is one segment-select stage, FRACTION_BITS + 1 divider stages
// of one quotient bit each, and the output register.
// Reset clears the registers (shape left shoulder, all points zero) and every
// valid bit; words in flight are dropped. The receiver cannot stall, so a
// result is shown for exactly one cycle and nothing waits.
module fuzzy_membership_evaluator #(
    parameter int VALUE_BITS    = fme_pkg::VALUE_BITS_DEF,
    parameter int FRACTION_BITS = fme_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input word
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [VALUE_BITS-1:0]          crisp_value,
    // result word
    output logic                                  done,
    output logic [FRACTION_BITS:0]                membership_degree,
    output logic                                  zero_span,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [fme_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [VALUE_BITS-1:0]                 cfg_wdata
);
    import fme_pkg::*;

    localparam int LATENCY = FRACTION_BITS + 3;
    localparam logic [FRACTION_BITS:0] DEGREE_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    shape_t                      shape_reg;
    logic signed [VALUE_BITS-1:0] point_a_reg;
    logic signed [VALUE_BITS-1:0] point_b_reg;
    logic signed [VALUE_BITS-1:0] point_c_reg;
    logic signed [VALUE_BITS-1:0] point_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg   <= SHAPE_LEFT_SHOULDER;
            point_a_reg <= '0;
            point_b_reg <= '0;
            point_c_reg <= '0;
            point_d_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SHAPE_KIND: shape_reg   <= shape_t'(cfg_wdata[SHAPE_BITS-1:0]);
                CFG_POINT_A:    point_a_reg <= cfg_wdata;
                CFG_POINT_B:    point_b_reg <= cfg_wdata;
                CFG_POINT_C:    point_c_reg <= cfg_wdata;
                CFG_POINT_D:    point_d_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Segment select: turn each case into a ratio num / den, with
    // num <= den and den > 0. A full degree becomes 1/1, a zero degree
    // 0/1, so every word takes the same path through the divider.
    // Differences are taken modulo 2^VALUE_BITS; wherever they are used
    // the true value is non-negative and fits.
    // ---------------------------------------------------------------
    logic                     accept;
    logic [VALUE_BITS-1:0]    num_next;
    logic [VALUE_BITS-1:0]    den_next;
    logic                     flag_next;

    localparam logic [VALUE_BITS-1:0] RATIO_ONE  = VALUE_BITS'(1);
    localparam logic [VALUE_BITS-1:0] RATIO_ZERO = '0;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        num_next  = RATIO_ZERO;
        den_next  = RATIO_ONE;
        flag_next = 1'b0;
        case (shape_reg)
            SHAPE_LEFT_SHOULDER:
            begin
                if (crisp_value < point_a_reg)
                begin
                    num_next = RATIO_ONE;
                end
                else if (crisp_value > point_b_reg)
                begin
                    num_next = RATIO_ZERO;
                end
                else if (point_b_reg == point_a_reg)
                begin
                    flag_next = 1'b1;
                end
                else
                begin
                    num_next = point_b_reg - crisp_value;
                    den_next = point_b_reg - point_a_reg;
                end
            end
            SHAPE_RIGHT_SHOULDER:
            begin
                if (crisp_value > point_b_reg)
                begin
                    num_next = RATIO_ONE;
                end
                else if (crisp_value < point_a_reg)
                begin
                    num_next = RATIO_ZERO;
                end
                else if (point_b_reg == point_a_reg)
                begin
                    flag_next = 1'b1;
                end
                else
                begin
                    num_next = crisp_value - point_a_reg;
                    den_next = point_b_reg - point_a_reg;
                end
            end
            SHAPE_TRIANGLE:
            begin
                // rise from a to the peak c, fall from c to b
                if (crisp_value == point_c_reg)
                begin
                    num_next = RATIO_ONE;
                end
                else if (crisp_value < point_c_reg)
                begin
                    if (crisp_value > point_a_reg)
                    begin
                        num_next = crisp_value - point_a_reg;
                        den_next = point_c_reg - point_a_reg;
                    end
                end
                else if (crisp_value < point_b_reg)
                begin
                    num_next = point_b_reg - crisp_value;
                    den_next = point_b_reg - point_c_reg;
                end
            end
            SHAPE_TRAPEZOID:
            begin
                if (crisp_value < point_a_reg || crisp_value > point_d_reg)
                begin
                    num_next = RATIO_ZERO;
                end
                else if (crisp_value < point_b_reg)
                begin
                    num_next = crisp_value - point_a_reg;
                    den_next = point_b_reg - point_a_reg;
                end
                else if (crisp_value > point_c_reg)
                begin
                    num_next = point_d_reg - crisp_value;
                    den_next = point_d_reg - point_c_reg;
                end
                else
                begin
                    num_next = RATIO_ONE;
                end
            end
            SHAPE_INTERVAL:
            begin
                if (crisp_value > point_a_reg && crisp_value < point_b_reg)
                begin
                    num_next = RATIO_ONE;
                end
            end
            SHAPE_SINGLETON:
            begin
                if (crisp_value == point_a_reg)
                begin
                    num_next = RATIO_ONE;
                end
            end
            default:
            begin
                // unused shape codes grade everything as zero
                num_next = RATIO_ZERO;
            end
        endcase
    end

    // Hold the ratio for the divider
    fme_side_t             sel_side_reg;
    logic [VALUE_BITS-1:0] sel_num_reg;
    logic [VALUE_BITS-1:0] sel_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_side_reg <= '0;
        end
        else
        begin
            sel_side_reg.valid     <= accept;
            sel_side_reg.zero_span <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_num_reg <= num_next;
        sel_den_reg <= den_next;
    end

    // ---------------------------------------------------------------
    // Divider: one quotient bit per stage
    // ---------------------------------------------------------------
    fme_side_t              div_side;
    logic [FRACTION_BITS:0] div_quot;

    fme_div_pipe #(
        .NUM_BITS      (VALUE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_side  (sel_side_reg),
        .num      (sel_num_reg),
        .den      (sel_den_reg),
        .out_side (div_side),
        .quot     (div_quot)
    );

    // ---------------------------------------------------------------
    // Output register: registers each finished word and raises done for one cycle
    // ---------------------------------------------------------------
    logic                   done_reg;
    logic [FRACTION_BITS:0] degree_reg;
    logic                   zero_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        degree_reg    <= div_quot;
        zero_span_reg <= div_side.zero_span;
    end

    assign done              = done_reg;
    assign membership_degree = degree_reg;
    assign zero_span         = zero_span_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_zero_span_degree: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && zero_span) |-> (membership_degree == '0)
    ) else $error("zero span word carries a non-zero degree");

    a_degree_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (membership_degree <= DEGREE_ONE)
    ) else $error("degree above one");

    a_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done
    ) else $error("accepted word did not come out after the pipeline latency");

    a_no_spurious: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY)
    ) else $error("result word without a matching accepted word");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the fuzzy membership evaluator: directed table, then random phases.
module tb;
    import fme_pkg::*;

    localparam int VB      = VALUE_BITS_DEF;
    localparam int FB      = FRACTION_BITS_DEF;
    // one select stage, FB + 1 divider stages, one output register
    localparam int LATENCY = FB + 3;

    localparam int VALUE_MIN = -(1 << (VB - 1));
    localparam int VALUE_MAX = (1 << (VB - 1)) - 1;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 16;
    localparam int WORDS_PER_PHASE = 100;
    localparam int SHAPE_COUNT     = 6;

    // shape codes the block does not define, and a register index it ignores
    localparam logic [SHAPE_BITS-1:0]     SHAPE_UNUSED_LO = 3'd6;
    localparam logic [SHAPE_BITS-1:0]     SHAPE_UNUSED_HI = 3'd7;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE       = 3'd7;

    localparam logic [FB:0] DEG_ONE  = {1'b1, {FB{1'b0}}};
    localparam logic [FB:0] DEG_ZERO = '0;

    typedef struct packed {
        logic [FB:0] degree;
        logic        zero_span;
    } grade_t;

    // one row of the directed table: register setting, crisp value, optional fixed answer
    typedef struct packed {
        logic [SHAPE_BITS-1:0] shape;
        logic [VB-1:0]         a;
        logic [VB-1:0]         b;
        logic [VB-1:0]         c;
        logic [VB-1:0]         d;
        logic [VB-1:0]         v;
        logic                  typed;
        grade_t                want;
    } probe_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [VB-1:0]      crisp_value;
    logic                      done;
    logic [FB:0]               membership_degree;
    logic                      zero_span;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [VB-1:0]             cfg_wdata;

    // shadow of the configuration registers, as the block holds them after reset
    logic [SHAPE_BITS-1:0] cur_shape = SHAPE_LEFT_SHOULDER;
    logic [VB-1:0]         cur_a     = '0;
    logic [VB-1:0]         cur_b     = '0;
    logic [VB-1:0]         cur_c     = '0;
    logic [VB-1:0]         cur_d     = '0;

    // grades owed by the block, oldest first
    grade_t pending_grades[$];

    int mismatches   = 0;
    int grades_seen  = 0;
    int cycle_count  = 0;

    fuzzy_membership_evaluator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .crisp_value       (crisp_value),
        .done              (done),
        .membership_degree (membership_degree),
        .zero_span         (zero_span),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop: a hung handshake or a lost result ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** fuzzy_membership_evaluator: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // ONE * num / den, truncated; num is never negative, den always positive
    function automatic longint ramp_degree(input longint num, input longint den);
        return (num << FB) / den;
    endfunction

    // Grade one crisp value against the shadow registers.
    function automatic grade_t membership_of(input logic [VB-1:0] raw);
        longint one;
        longint v;
        longint a;
        longint b;
        longint c;
        longint d;
        longint deg;
        grade_t g;
        one = longint'(1) << FB;
        v   = longint'($signed(raw));
        a   = longint'($signed(cur_a));
        b   = longint'($signed(cur_b));
        c   = longint'($signed(cur_c));
        d   = longint'($signed(cur_d));
        deg = 0;
        g.zero_span = 1'b0;
        case (cur_shape)
            SHAPE_LEFT_SHOULDER:
                if (v < a) deg = one;
                else if (v > b) deg = 0;
                else if (b == a) g.zero_span = 1'b1;  // flat segment: flag it, grade 0
                else deg = ramp_degree(b - v, b - a);
            SHAPE_RIGHT_SHOULDER:
                if (v > b) deg = one;
                else if (v < a) deg = 0;
                else if (b == a) g.zero_span = 1'b1;
                else deg = ramp_degree(v - a, b - a);
            SHAPE_TRIANGLE:
                // rise from a to the peak c, fall from c to b
                if (v == c) deg = one;
                else if (v < c) deg = (v <= a) ? 0 : ramp_degree(v - a, c - a);
                else deg = (v >= b) ? 0 : ramp_degree(b - v, b - c);
            SHAPE_TRAPEZOID:
                if (v < a || v > d) deg = 0;
                else if (v < b) deg = ramp_degree(v - a, b - a);
                else if (v > c) deg = ramp_degree(d - v, d - c);
                else deg = one;
            SHAPE_INTERVAL:
                deg = (v > a && v < b) ? one : 0;
            SHAPE_SINGLETON:
                deg = (v == a) ? one : 0;
            default:
                deg = 0;
        endcase
        g.degree = deg[FB:0];
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    function automatic probe_t row(input logic [SHAPE_BITS-1:0] shape, input int a, input int b,
                                   input int c, input int d, input int v, input logic typed,
                                   input logic [FB:0] degree, input logic zs);
        probe_t p;
        p.shape          = shape;
        p.a              = VB'(a);
        p.b              = VB'(b);
        p.c              = VB'(c);
        p.d              = VB'(d);
        p.v              = VB'(v);
        p.typed          = typed;
        p.want.degree    = degree;
        p.want.zero_span = zs;
        return p;
    endfunction

    function automatic int rand_point();
        logic [VB-1:0] r;
        r = VB'($urandom);
        return int'($signed(r));
    endfunction

    function automatic int clamp_value(input int x);
        if (x < VALUE_MIN) return VALUE_MIN;
        if (x > VALUE_MAX) return VALUE_MAX;
        return x;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Write one register; update the shadow at the edge that takes it.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [VB-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_SHAPE_KIND: cur_shape = data[SHAPE_BITS-1:0];
            CFG_POINT_A:    cur_a     = data;
            CFG_POINT_B:    cur_b     = data;
            CFG_POINT_C:    cur_c     = data;
            CFG_POINT_D:    cur_d     = data;
            default:        ;
        endcase
    endtask

    // Load a whole setting; the block must be idle. Optionally poke the unused index too.
    task automatic load_set(input logic [SHAPE_BITS-1:0] shape, input logic [VB-1:0] a,
                            input logic [VB-1:0] b, input logic [VB-1:0] c,
                            input logic [VB-1:0] d, input logic [VB-SHAPE_BITS-1:0] pad,
                            input logic poke_spare);
        write_reg(CFG_SHAPE_KIND, {pad, shape});
        write_reg(CFG_POINT_A, a);
        write_reg(CFG_POINT_B, b);
        write_reg(CFG_POINT_C, c);
        write_reg(CFG_POINT_D, d);
        if (poke_spare)
            write_reg(CFG_SPARE, VB'($urandom));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one word and hold it until taken; then book its grade.
    task automatic send_crisp(input logic [VB-1:0] v, input logic typed, input grade_t fixed);
        @(negedge clk);
        start       <= 1'b1;
        crisp_value <= v;
        do @(posedge clk); while (busy !== 1'b0);
        pending_grades.push_back(typed ? fixed : membership_of(v));
    endtask

    // Drop start for a number of cycles.
    task automatic pause_words(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Drop start and wait for every grade owed.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_grades.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: every done pulse is matched with the oldest grade owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : grade_check
        grade_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            grades_seen++;
            if (pending_grades.size() == 0)
            begin
                report_mismatch($sformatf("unexpected grade: degree %0d zero_span %0b",
                                          membership_degree, zero_span));
            end
            else
            begin
                want = pending_grades.pop_front();
                if (membership_degree !== want.degree)
                    report_mismatch($sformatf("grade %0d: degree %0d, predicted %0d",
                                              grades_seen, membership_degree, want.degree));
                if (zero_span !== want.zero_span)
                    report_mismatch($sformatf("grade %0d: zero_span %0b, predicted %0b",
                                              grades_seen, zero_span, want.zero_span));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        probe_t                   probes[$];
        probe_t                   p;
        int                       pts[4];
        int                       lo;
        int                       hi;
        int                       centre;
        int                       span;
        int                       mode;
        int                       pick;
        int                       gap;
        int                       burst;
        int                       tmp;
        int                       i;
        int                       j;
        logic [SHAPE_BITS-1:0]    shape;
        logic [VB-1:0]            a;
        logic [VB-1:0]            b;
        logic [VB-1:0]            c;
        logic [VB-1:0]            d;
        logic [VB-SHAPE_BITS-1:0] pad;
        logic [VB-1:0]            v;

        // every input known from time zero
        rst_n       = 1'b0;
        start       = 1'b0;
        crisp_value = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_SHAPE_KIND;
        cfg_wdata   = '0;

        // Directed table. The first rows run on the reset setting: a left
        // shoulder collapsed onto zero, which is the zero-width case.
        probes.push_back(row(SHAPE_LEFT_SHOULDER, 0, 0, 0, 0, 0, 1'b1, DEG_ZERO, 1'b1));
        probes.push_back(row(SHAPE_LEFT_SHOULDER, 0, 0, 0, 0, -1, 1'b1, DEG_ONE, 1'b0));
        probes.push_back(row(SHAPE_LEFT_SHOULDER, 0, 0, 0, 0, 1, 1'b1, DEG_ZERO, 1'b0));
        // full-range slopes: widest divisor
        probes.push_back(row(SHAPE_LEFT_SHOULDER, VALUE_MIN, VALUE_MAX, 0, 0, VALUE_MIN,
                             1'b0, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_LEFT_SHOULDER, VALUE_MIN, VALUE_MAX, 0, 0, VALUE_MAX,
                             1'b0, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_RIGHT_SHOULDER, VALUE_MIN, VALUE_MAX, 0, 0, VALUE_MAX,
                             1'b0, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_RIGHT_SHOULDER, VALUE_MIN, VALUE_MAX, 0, 0, VALUE_MIN,
                             1'b0, DEG_ZERO, 1'b0));
        // right shoulder of zero width
        probes.push_back(row(SHAPE_RIGHT_SHOULDER, 5, 5, 0, 0, 5, 1'b1, DEG_ZERO, 1'b1));
        probes.push_back(row(SHAPE_RIGHT_SHOULDER, 5, 5, 0, 0, 6, 1'b1, DEG_ONE, 1'b0));
        // triangle a = -10, peak c = 0, foot b = 10
        probes.push_back(row(SHAPE_TRIANGLE, -10, 10, 0, 0, 0, 1'b1, DEG_ONE, 1'b0));
        probes.push_back(row(SHAPE_TRIANGLE, -10, 10, 0, 0, -5, 1'b0, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_TRIANGLE, -10, 10, 0, 0, -10, 1'b1, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_TRIANGLE, -10, 10, 0, 0, 10, 1'b1, DEG_ZERO, 1'b0));
        // trapezoid: rising edge, plateau, falling edge, outside
        probes.push_back(row(SHAPE_TRAPEZOID, -20, -10, 10, 20, -15, 1'b0, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_TRAPEZOID, -20, -10, 10, 20, 0, 1'b1, DEG_ONE, 1'b0));
        probes.push_back(row(SHAPE_TRAPEZOID, -20, -10, 10, 20, 15, 1'b0, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_TRAPEZOID, -20, -10, 10, 20, 21, 1'b1, DEG_ZERO, 1'b0));
        // open interval excludes its ends
        probes.push_back(row(SHAPE_INTERVAL, -3, 3, 0, 0, -3, 1'b1, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_INTERVAL, -3, 3, 0, 0, 0, 1'b1, DEG_ONE, 1'b0));
        // singleton at the most negative value
        probes.push_back(row(SHAPE_SINGLETON, VALUE_MIN, 0, 0, 0, VALUE_MIN, 1'b1, DEG_ONE, 1'b0));
        probes.push_back(row(SHAPE_SINGLETON, VALUE_MIN, 0, 0, 0, VALUE_MAX, 1'b1, DEG_ZERO, 1'b0));
        // unused shape codes grade 0 without the flag
        probes.push_back(row(SHAPE_UNUSED_LO, 0, 0, 0, 0, 0, 1'b1, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_UNUSED_HI, VALUE_MIN, VALUE_MAX, VALUE_MIN, VALUE_MAX,
                             VALUE_MIN, 1'b1, DEG_ZERO, 1'b0));
        // misordered breakpoints
        probes.push_back(row(SHAPE_TRAPEZOID, 10, -10, 20, 5, 7, 1'b0, DEG_ZERO, 1'b0));
        probes.push_back(row(SHAPE_TRIANGLE, 10, -10, 0, 0, 5, 1'b0, DEG_ZERO, 1'b0));

        // hold reset, then release it away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the table; reload registers only when a row needs a new setting.
        foreach (probes[k])
        begin
            p = probes[k];
            if (p.shape != cur_shape || p.a != cur_a || p.b != cur_b ||
                p.c != cur_c || p.d != cur_d)
            begin
                drain();
                load_set(p.shape, p.a, p.b, p.c, p.d, '0, 1'b0);
            end
            send_crisp(p.v, p.typed, p.want);
        end
        drain();

        // Random phases: one setting each, words in bursts, with gaps on most phases.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // walk every shape twice, then let the code run free, unused codes included
            if (phase < 2 * SHAPE_COUNT)
                shape = SHAPE_BITS'(phase % SHAPE_COUNT);
            else
                shape = SHAPE_BITS'($urandom);

            // Breakpoint flavour: full-range extremes on a few phases, else mostly
            // ordered points in a window of random width, with some misordered and
            // some collapsed sets.
            if (phase < 2 || phase == 8 || phase == 9)
                mode = 0;
            else
                mode = $urandom_range(1, 9);

            centre = rand_point();
            span   = 1 << $urandom_range(0, 14);
            for (i = 0; i < 4; i++)
            begin
                case (mode)
                    0:       pts[i] = (i == 0) ? VALUE_MIN : (i == 3) ? VALUE_MAX : rand_point();
                    6, 7:    pts[i] = rand_point();
                    8:       pts[i] = centre;
                    9:       pts[i] = (i < 2) ? centre : centre + $urandom_range(1, span);
                    default: pts[i] = centre + $urandom_range(0, span);
                endcase
                pts[i] = clamp_value(pts[i]);
            end
            // leave the misordered flavour unsorted
            if (mode != 7)
            begin
                for (i = 0; i < 3; i++)
                begin
                    for (j = 0; j < 3 - i; j++)
                    begin
                        if (pts[j] > pts[j + 1])
                        begin
                            tmp        = pts[j];
                            pts[j]     = pts[j + 1];
                            pts[j + 1] = tmp;
                        end
                    end
                end
            end
            lo = pts[0];
            hi = pts[0];
            for (i = 1; i < 4; i++)
            begin
                if (pts[i] < lo) lo = pts[i];
                if (pts[i] > hi) hi = pts[i];
            end

            // map the points onto the registers the shape reads; fill the rest at random
            a = VB'(pts[0]);
            b = VB'(pts[3]);
            c = VB'($urandom);
            d = VB'($urandom);
            if (shape == SHAPE_TRIANGLE)
                c = VB'(pts[$urandom_range(1, 2)]);
            if (shape == SHAPE_TRAPEZOID)
            begin
                b = VB'(pts[1]);
                c = VB'(pts[2]);
                d = VB'(pts[3]);
            end

            // junk above the shape field half the time
            if ($urandom_range(0, 1) == 1)
                pad = (VB - SHAPE_BITS)'($urandom);
            else
                pad = '0;
            load_set(shape, a, b, c, d, pad, phase % 3 == 0);

            burst = 0;
            for (int word_no = 0; word_no < WORDS_PER_PHASE; word_no++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 24);
                    // every fourth phase streams with no gaps at all
                    if (phase % 4 != 3)
                    begin
                        pick = $urandom_range(0, 7);
                        if (pick < 5)
                            gap = $urandom_range(1, 4);
                        else if (pick < 7)
                            gap = $urandom_range(5, 12);
                        else
                            gap = $urandom_range(LATENCY - 3, LATENCY + 8);
                        pause_words(gap);
                    end
                end

                // hold off mid-phase until the pipeline is empty
                if (phase == 5 && word_no == WORDS_PER_PHASE / 2)
                    drain();

                // crisp value: near a breakpoint, in or just around the span, on a breakpoint, or anywhere
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    tmp = pts[$urandom_range(0, 3)] + $urandom_range(0, 6) - 3;
                else if (pick < 7)
                    tmp = lo - 8 + $urandom_range(0, hi - lo + 16);
                else if (pick == 7)
                    tmp = pts[$urandom_range(0, 3)];
                else
                    tmp = rand_point();
                v = VB'(clamp_value(tmp));

                send_crisp(v, 1'b0, '0);
                burst--;
            end
            drain();
        end

        // let any stray pulse show up before the verdict
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("** fuzzy_membership_evaluator: PASSED **");
        else
            $display("** fuzzy_membership_evaluator: FAILED **");
        $finish;
    end

endmodule
